>>> rtl/sef_pkg.sv
// ----------------------------------------------------------------------------
// Stereo envelope follower package
// Shared types, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package sef_pkg;

   localparam int SAMPLE_W = 24;
   localparam int ENV_W = 23;
   localparam int GAIN_W = 16;
   localparam int SQ_W = 47;
   localparam int SUM_W = 54;
   localparam int POS_W = 7;
   localparam int RING_DEPTH = 128;
   localparam int MEAN_SHIFT = 7;
   localparam int ROOT_W = 24;
   localparam int STEP_W = 5;
   localparam int SQ_STEPS = 24;
   localparam int ROOT_STEPS = 24;
   localparam int MUL_STEPS = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};
   localparam logic [GAIN_W-1:0] ATTACK_RESET = 16'd65000;
   localparam logic [GAIN_W-1:0] RELEASE_RESET = 16'd65500;

   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_GAIN = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } sef_req_type;

   typedef struct packed {
      logic [ENV_W-1:0] left_envelope;
      logic [ENV_W-1:0] right_envelope;
   } sef_rsp_type;

   typedef struct packed {
      logic start;
      logic mode;
      logic [POS_W-1:0] pos;
      logic [GAIN_W-1:0] attack;
      logic [GAIN_W-1:0] release_g;
   } sef_ctl_type;

   typedef struct packed {
      logic done;
      logic [ENV_W-1:0] env;
   } sef_sts_type;

endpackage

>>> rtl/sef_isqrt.sv
// ----------------------------------------------------------------------------
// Serial integer square root
// Restoring square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sef_isqrt
   import sef_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SQ_W-1:0]        radicand,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);

   logic                    busy_ff;
   logic [STEP_W-1:0]       cnt_ff;
   logic [2*ROOT_W-1:0]     rad_ff;
   logic [ROOT_W+1:0]       rem_ff;
   logic [ROOT_W-1:0]       root_ff;
   logic                    done_ff;
   logic [ROOT_W+3:0]       rem_sh;
   logic [ROOT_W+3:0]       trial;
   logic                    fits;

   assign rem_sh = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign fits = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff <= {1'b0, radicand};
         rem_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[2*ROOT_W-3:0], 2'b00};
         if (fits) begin
            rem_ff <= (ROOT_W + 2)'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[ROOT_W+1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/sef_channel.sv
// ----------------------------------------------------------------------------
// Envelope follower channel
// Detector, 128-entry square ring with running sum, and bit-serial
// attack/release smoothing for one audio channel.
// ----------------------------------------------------------------------------
module sef_channel
   import sef_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  sef_ctl_type                 ctl,
   input  logic signed [SAMPLE_W-1:0]  sample,
   output sef_sts_type                 sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_PREP   = 3'd4;
   localparam logic [2:0] ST_SMOOTH = 3'd5;

   localparam int ACC_W = ENV_W + GAIN_W + 2;

   logic [2:0]               state_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [STEP_W-1:0]        cnt_ff;
   logic [SQ_W-1:0]          mcand_ff;
   logic [SAMPLE_W-1:0]      mplier_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         sum_in;
   logic [SQ_W-1:0]          rd_ff;
   logic                     rd_valid_ff;
   logic [RING_DEPTH-1:0]    valid_ff;
   logic [SQ_W-1:0]          ring [RING_DEPTH];
   logic [ENV_W-1:0]         det_ff;
   logic [ENV_W-1:0]         env_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  dmul_ff;
   logic [GAIN_W-1:0]        gmul_ff;
   logic                     done_ff;
   logic [SAMPLE_W-1:0]      mag;
   logic [SQ_W-1:0]          old_sq;
   logic                     root_start;
   logic                     root_done;
   logic [ROOT_W-1:0]        root;

   assign mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign old_sq = rd_valid_ff ? rd_ff : '0;
   assign sum_in = sum_ff + SUM_W'(sq_ff) - SUM_W'(old_sq);
   assign root_start = (state_ff == ST_SUM);
   assign acc_in = gmul_ff[0] ? (acc_ff + dmul_ff) : acc_ff;

   sef_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_in[SUM_W-1:MEAN_SHIFT]),
      .done     (root_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         sum_ff <= '0;
         env_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (ctl.start) begin
                  if (ctl.mode) begin
                     state_ff <= ST_SQUARE;
                  end else begin
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_SQUARE: begin
               if (cnt_ff == STEP_W'(SQ_STEPS - 1)) begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               sum_ff <= sum_in;
               valid_ff[pos_ff] <= 1'b1;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (root_done) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               state_ff <= ST_SMOOTH;
            end
            ST_SMOOTH: begin
               if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
                  env_ff <= acc_in[ENV_W+GAIN_W-1:GAIN_W];
                  done_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            pos_ff <= ctl.pos;
            cnt_ff <= '0;
            mcand_ff <= SQ_W'(mag);
            mplier_ff <= mag;
            sq_ff <= '0;
            det_ff <= mag[SAMPLE_W-1] ? ENV_MAX : mag[ENV_W-1:0];
         end
         ST_SQUARE: begin
            if (mplier_ff[0]) begin
               sq_ff <= sq_ff + mcand_ff;
            end
            mcand_ff <= {mcand_ff[SQ_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[SAMPLE_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
         end
         ST_ROOT: begin
            if (root_done) begin
               det_ff <= root[ROOT_W-1] ? ENV_MAX : root[ENV_W-1:0];
            end
         end
         ST_PREP: begin
            cnt_ff <= '0;
            gmul_ff <= (env_ff < det_ff) ? ctl.attack : ctl.release_g;
            dmul_ff <= ACC_W'(signed'({1'b0, env_ff}) - signed'({1'b0, det_ff}));
            acc_ff <= signed'({2'b00, det_ff, {GAIN_W{1'b0}}});
         end
         ST_SMOOTH: begin
            acc_ff <= acc_in;
            dmul_ff <= dmul_ff <<< 1;
            gmul_ff <= {1'b0, gmul_ff[GAIN_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && ctl.start) begin
         rd_ff <= ring[ctl.pos];
         rd_valid_ff <= valid_ff[ctl.pos];
      end
      if (state_ff == ST_SUM) begin
         ring[pos_ff] <= sq_ff;
      end
   end

   assign sts.done = done_ff;
   assign sts.env = env_ff;

endmodule

>>> rtl/stereo_envelope_follower.sv
// ----------------------------------------------------------------------------
// Stereo envelope follower
// Peak or windowed RMS detector with attack/release smoothing per channel.
//
//   Channel   Ports                            Carries
//   req       req_valid, req_ready, req_data   one stereo sample word
//   rsp       rsp_valid, rsp_ready, rsp_data   one stereo envelope word
//   csr       csr_wr_en, csr_index, csr_wr_data  mode and gain registers
//
// An RMS-mode word runs the serial square, the ring update, the serial root,
// the serial gain multiply and the hand-out of the result, in that order. A
// peak-mode word runs only the serial gain multiply and the hand-out.
// Synchronous reset clears the envelopes, running sums and ring valid bits.
// A finished result waits in the output register while the next word runs;
// a further result waits in the channels until the output register frees.
// ----------------------------------------------------------------------------
module stereo_envelope_follower
   import sef_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sef_req_type             req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sef_rsp_type             rsp_data,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [GAIN_W-1:0]       csr_wr_data
);

   logic                mode_ff;
   logic [GAIN_W-1:0]   attack_ff;
   logic [GAIN_W-1:0]   release_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                busy_ff;
   logic                pending_ff;
   logic                rsp_valid_ff;
   sef_rsp_type         rsp_data_ff;
   logic                req_fire;
   logic                rsp_free;
   sef_ctl_type         ctl;
   sef_sts_type         left_sts;
   sef_sts_type         right_sts;

   assign req_ready = !busy_ff;
   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign ctl.start = req_fire;
   assign ctl.mode = mode_ff;
   assign ctl.pos = pos_ff;
   assign ctl.attack = attack_ff;
   assign ctl.release_g = release_ff;

   sef_channel u_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_data.left_sample),
      .sts    (left_sts)
   );

   sef_channel u_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_data.right_sample),
      .sts    (right_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         attack_ff <= ATTACK_RESET;
         release_ff <= RELEASE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DETECT_MODE: begin
               mode_ff <= csr_wr_data[0];
            end
            CSR_ATTACK_GAIN: begin
               attack_ff <= csr_wr_data;
            end
            CSR_RELEASE_GAIN: begin
               release_ff <= csr_wr_data;
            end
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         busy_ff <= 1'b0;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            busy_ff <= 1'b1;
            if (mode_ff) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         if (left_sts.done) begin
            pending_ff <= 1'b1;
         end
         if (pending_ff && rsp_free) begin
            pending_ff <= 1'b0;
            busy_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pending_ff && rsp_free) begin
         rsp_data_ff.left_envelope <= left_sts.env;
         rsp_data_ff.right_envelope <= right_sts.env;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Both channels run the same schedule, so they finish together.
   assert property (@(posedge clock) disable iff (reset)
      left_sts.done == right_sts.done)
      else $error("channel completions out of step");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_ff |=> pos_ff == POS_W'($past(pos_ff) + 1'b1))
      else $error("ring position did not advance on an RMS word");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pending_ff))
      else $error("result presented without a finished word");

   assert property (@(posedge clock) disable iff (reset)
      left_sts.done |-> busy_ff && !pending_ff)
      else $error("channel finished while no word was in progress");

endmodule
